FILE: sv/pawt_pkg.sv
package pawt_pkg;

    // Field widths of the sequence number and the acknowledgement bitfield.
    localparam int SEQ_W      = 16;
    localparam int MASK_W     = 32;
    localparam int MASK_IDX_W = $clog2(MASK_W);

    // Fixed sequence values.
    localparam logic [SEQ_W-1:0] ACK_RESET  = 16'hFFFF;
    localparam logic [SEQ_W-1:0] SEQ_MAX    = 16'hFFFF;
    localparam logic [SEQ_W-1:0] HALF_RANGE = 16'h8000;

    // One slot of the sequence table: a valid flag and the stored sequence.
    typedef struct packed {
        logic             valid;
        logic [SEQ_W-1:0] tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Sequencer states of the tracker.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_RD,
        S_EVAL,
        S_WALK,
        S_OUT
    } t_state;

endpackage

FILE: sv/pawt_ram.sv
module pawt_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/packet_ack_window_tracker.sv
// Channel  | Valid        | Stall        | Payload
// ---------+--------------+--------------+-----------------------------------------------
// input    | i_in_valid   | o_in_stall   | i_seq_number
// output   | o_out_valid  | i_out_stall  | o_accepted, o_is_newer, o_ack_seq, o_ack_mask
//
// One packet is handled at a time. Every packet passes through S_DIV, S_RD and S_EVAL.
// A rejected packet then goes to S_OUT; an accepted one first passes S_WALK, where for a
// newer packet the single write port of the sequence table clears one skipped slot per
// cycle, at most SEQ_TABLE_DEPTH of them, before the new tag is written.
// After reset the table is cleared in S_CLEAR while o_in_stall is high.
// A new packet may be taken while a result waits in the output register; the sequencer
// then holds its next result until that transfer completes.
module packet_ack_window_tracker #(
    parameter int SEQ_TABLE_DEPTH = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [pawt_pkg::SEQ_W-1:0]  i_seq_number,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_accepted,
    output logic                        o_is_newer,
    output logic [pawt_pkg::SEQ_W-1:0]  o_ack_seq,
    output logic [pawt_pkg::MASK_W-1:0] o_ack_mask
);

    import pawt_pkg::*;

    // Slot index arithmetic: slot = seq mod depth, by a reciprocal multiply.
    localparam int SLOT_W  = $clog2(SEQ_TABLE_DEPTH);
    localparam int CNT_W   = $clog2(SEQ_TABLE_DEPTH + 1);
    localparam int RECIP_W = 33 - SLOT_W;
    localparam int PROD_W  = SEQ_W + RECIP_W;
    localparam longint unsigned RECIP_L =
        ((64'd1 << 32) + longint'(SEQ_TABLE_DEPTH) - 1) / longint'(SEQ_TABLE_DEPTH);
    localparam logic [RECIP_W-1:0] RECIP        = RECIP_W'(RECIP_L);
    localparam logic [SEQ_W-1:0]   DEPTH_SEQ    = SEQ_W'(SEQ_TABLE_DEPTH);
    localparam logic [SLOT_W-1:0]  LAST_SLOT    = SLOT_W'(SEQ_TABLE_DEPTH - 1);
    localparam logic [SLOT_W-1:0]  ACK_SLOT_RST = SLOT_W'(65535 % SEQ_TABLE_DEPTH);
    localparam logic [CNT_W-1:0]   DEPTH_CNT    = CNT_W'(SEQ_TABLE_DEPTH);
    localparam logic [SEQ_W-1:0]   MASK_SPAN    = SEQ_W'(MASK_W);

    // Control and tracking state.
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [SLOT_W-1:0]   r_wslot, n_wslot;
    logic [SEQ_W-1:0]    r_wseq, n_wseq;
    logic [SEQ_W-1:0]    r_ack, n_ack;
    logic [MASK_W-1:0]   r_mask, n_mask;
    logic [SLOT_W-1:0]   r_ack_slot, n_ack_slot;
    logic                r_out_valid, n_out_valid;

    // Per-packet working registers.
    logic [SEQ_W-1:0]    r_seq;
    logic [PROD_W-1:0]   r_prod;
    logic [SEQ_W-1:0]    r_qd;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_acc, n_acc;
    logic                r_new, n_new;

    // Output register.
    logic                r_out_acc;
    logic                r_out_new;
    logic [SEQ_W-1:0]    r_out_ack;
    logic [MASK_W-1:0]   r_out_mask;

    // Table port signals.
    logic                w_wr_en;
    logic [SLOT_W-1:0]   w_wr_addr;
    t_entry              w_wr_entry;
    logic                w_rd_en;
    logic [ENTRY_W-1:0]  w_rd_data;
    t_entry              w_rd_entry;

    // Combinational helpers.
    logic [SEQ_W-1:0]    w_qd;
    logic [SLOT_W-1:0]   w_slot_calc;
    logic [SLOT_W-1:0]   w_wslot_next;
    logic [SLOT_W-1:0]   w_ack_slot_next;
    logic [SEQ_W-1:0]    w_dist;
    logic [SEQ_W-1:0]    w_skipped;
    logic [SEQ_W-1:0]    w_back_m1;
    logic [MASK_W-1:0]   w_shift_in;
    logic [MASK_W-1:0]   w_mask_newer;
    logic                w_dup;
    logic                w_accept;
    logic                w_newer;
    logic                w_full;
    logic                w_out_free;
    logic                w_take_in;
    logic                w_load_out;

    pawt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SEQ_TABLE_DEPTH)
    ) u_tags (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_entry),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_slot_calc),
        .o_rd_data (w_rd_data)
    );

    assign w_rd_entry = t_entry'(w_rd_data);

    // Quotient times depth, then the remainder gives the slot of the packet.
    assign w_qd        = SEQ_W'(r_prod[PROD_W-1:32]) * DEPTH_SEQ;
    assign w_slot_calc = SLOT_W'(r_seq - r_qd);

    // Successor slots: the slot sequence restarts at zero after the last slot or when the sequence wraps.
    assign w_wslot_next    = (r_wseq == SEQ_MAX || r_wslot == LAST_SLOT)
                             ? '0 : r_wslot + 1'b1;
    assign w_ack_slot_next = (r_ack == SEQ_MAX || r_ack_slot == LAST_SLOT)
                             ? '0 : r_ack_slot + 1'b1;

    // Classification of the packet against the table entry and the ack.
    assign w_dist    = r_seq - r_ack;
    assign w_skipped = w_dist - 1'b1;
    assign w_back_m1 = ~w_dist;
    assign w_dup     = w_rd_entry.valid && (w_rd_entry.tag == r_seq);
    assign w_accept  = !w_dup && (w_dist != '0);
    assign w_newer   = (w_dist < HALF_RANGE) || (w_dist == HALF_RANGE && r_seq < r_ack);
    assign w_full    = (w_skipped >= DEPTH_SEQ);

    // Bitfield after an advance: the old ack enters as bit 0, then the gap shifts in.
    assign w_shift_in   = {r_mask[MASK_W-2:0], 1'b1};
    assign w_mask_newer = (w_skipped >= MASK_SPAN)
                          ? '0 : w_shift_in << w_skipped[MASK_IDX_W-1:0];

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_take_in  = (r_state == S_IDLE) && i_in_valid;
    assign w_load_out = (r_state == S_OUT) && w_out_free;

    // Sequencer: next state, table accesses and tracking state updates.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_wslot     = r_wslot;
        n_wseq      = r_wseq;
        n_ack       = r_ack;
        n_mask      = r_mask;
        n_ack_slot  = r_ack_slot;
        n_acc       = r_acc;
        n_new       = r_new;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_wslot;
        w_wr_entry  = '0;
        w_rd_en     = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            S_CLEAR: begin
                w_wr_en = 1'b1;
                n_cnt   = r_cnt - 1'b1;
                n_wslot = w_wslot_next;
                n_wseq  = r_wseq + 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_state = S_RD;
            end
            S_RD: begin
                w_rd_en = 1'b1;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_acc = w_accept;
                n_new = w_accept && w_newer;
                n_cnt = '0;
                if (w_accept && w_newer) begin
                    // Advance the ack and set up the walk over the skipped slots.
                    n_cnt      = w_full ? DEPTH_CNT : CNT_W'(w_skipped);
                    n_wseq     = w_full ? '0 : r_ack + 1'b1;
                    n_wslot    = w_full ? '0 : w_ack_slot_next;
                    n_ack      = r_seq;
                    n_ack_slot = r_slot;
                    n_mask     = w_mask_newer;
                end else if (w_accept && w_back_m1 < MASK_SPAN) begin
                    n_mask = r_mask | (MASK_W'(1) << w_back_m1[MASK_IDX_W-1:0]);
                end
                n_state = w_accept ? S_WALK : S_OUT;
            end
            S_WALK: begin
                w_wr_en = 1'b1;
                if (r_cnt != '0) begin
                    n_cnt   = r_cnt - 1'b1;
                    n_wslot = w_wslot_next;
                    n_wseq  = r_wseq + 1'b1;
                end else begin
                    // The packet's own tag goes in last, so it always survives.
                    w_wr_addr        = r_slot;
                    w_wr_entry.valid = 1'b1;
                    w_wr_entry.tag   = r_seq;
                    n_state          = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= DEPTH_CNT;
            r_wslot     <= '0;
            r_wseq      <= '0;
            r_ack       <= ACK_RESET;
            r_mask      <= '0;
            r_ack_slot  <= ACK_SLOT_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_wslot     <= n_wslot;
            r_wseq      <= n_wseq;
            r_ack       <= n_ack;
            r_mask      <= n_mask;
            r_ack_slot  <= n_ack_slot;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers of the packet in flight.
    always_ff @(posedge i_clk) begin
        if (w_take_in) begin
            r_seq  <= i_seq_number;
            r_prod <= PROD_W'(i_seq_number) * PROD_W'(RECIP);
        end
        if (r_state == S_DIV) begin
            r_qd <= w_qd;
        end
        if (r_state == S_RD) begin
            r_slot <= w_slot_calc;
        end
        r_acc <= n_acc;
        r_new <= n_new;
    end

    // Result register towards the output channel.
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_acc  <= r_acc;
            r_out_new  <= r_new;
            r_out_ack  <= r_ack;
            r_out_mask <= r_mask;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_accepted  = r_out_acc;
    assign o_is_newer  = r_out_new;
    assign o_ack_seq   = r_out_ack;
    assign o_ack_mask  = r_out_mask;

endmodule

FILE: sv/pawt_checker.sv
module pawt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic                        o_accepted,
    input logic                        o_is_newer,
    input logic [pawt_pkg::SEQ_W-1:0]  o_ack_seq,
    input logic [pawt_pkg::MASK_W-1:0] o_ack_mask
);

    import pawt_pkg::*;

    logic              w_xfer;
    logic [SEQ_W-1:0]  r_prev_ack;
    logic [MASK_W-1:0] r_prev_mask;

    assign w_xfer = o_out_valid && !i_out_stall;

    // Ack and bitfield as left by the previous result transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_ack  <= ACK_RESET;
            r_prev_mask <= '0;
        end else if (w_xfer) begin
            r_prev_ack  <= o_ack_seq;
            r_prev_mask <= o_ack_mask;
        end
    end

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_ack_seq)
            && $stable(o_ack_mask) && $stable(o_accepted) && $stable(o_is_newer))
        else $error("stalled result changed");

    // A rejected packet leaves the ack and the bitfield untouched.
    a_reject_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer && !o_accepted |-> o_ack_seq == r_prev_ack && o_ack_mask == r_prev_mask)
        else $error("rejected packet changed the window");

    // An accepted older packet keeps the ack.
    a_older_keeps_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer && o_accepted && !o_is_newer |-> o_ack_seq == r_prev_ack)
        else $error("older packet moved the ack");

    // A newer packet always moves the ack.
    a_newer_moves_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer && o_is_newer |-> o_accepted && o_ack_seq != r_prev_ack)
        else $error("newer packet did not move the ack");

    // Reset empties the output and stalls input while the table is cleared.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("block not quiet after reset");

endmodule

bind packet_ack_window_tracker pawt_checker u_pawt_checker (.*);

FILE: tb/sv/packet_ack_window_tracker_tb.sv
`timescale 1ns / 1ps

module packet_ack_window_tracker_tb;

    import pawt_pkg::*;

    localparam int TABLE_DEPTH   = 256;
    localparam int DIRECTED_N    = 25;
    localparam int RANDOM_N      = 725;
    localparam int HISTORY_N     = 8;
    localparam int HOLD_OFF_AT   = 200;
    localparam int HOLD_OFF_LEN  = 400;
    localparam int SETTLE_CYCLES = 300;
    localparam int REPORT_LIMIT  = 10;

    // One result of the tracker, field by field.
    typedef struct packed {
        logic              accepted;
        logic              is_newer;
        logic [SEQ_W-1:0]  ack_seq;
        logic [MASK_W-1:0] ack_mask;
    } t_ack_result;

    // One directed packet; has_value marks a result that is written out by hand.
    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic             has_value;
        t_ack_result      value;
    } t_probe_row;

    localparam t_ack_result NO_VALUE = '0;

    localparam t_probe_row DIRECTED_ROWS [DIRECTED_N] = '{
        // Equal to the reset ack, then the first packet, then its duplicate.
        '{16'hFFFF, 1'b1, '{1'b0, 1'b0, 16'hFFFF, 32'h0000_0000}},
        '{16'h0000, 1'b1, '{1'b1, 1'b1, 16'h0000, 32'h0000_0001}},
        '{16'h0000, 1'b1, '{1'b0, 1'b0, 16'h0000, 32'h0000_0001}},
        // Small gap, an older packet just behind the ack and its duplicate.
        '{16'h0003, 1'b0, NO_VALUE},
        '{16'h0002, 1'b0, NO_VALUE},
        '{16'h0002, 1'b0, NO_VALUE},
        // A gap of 31, then an older packet just outside the window.
        '{16'h0022, 1'b0, NO_VALUE},
        '{16'h0001, 1'b0, NO_VALUE},
        // Gaps of 32 and 33: the second clears the bitfield.
        '{16'h0042, 1'b0, NO_VALUE},
        '{16'h0063, 1'b1, '{1'b1, 1'b1, 16'h0063, 32'h0000_0000}},
        // Oldest bit of the window, then the newest, both in cleared slots.
        '{16'h0043, 1'b1, '{1'b1, 1'b0, 16'h0063, 32'h8000_0000}},
        '{16'h0062, 1'b0, NO_VALUE},
        // A gap equal to the table depth, then one that clears every slot.
        '{16'h0163, 1'b0, NO_VALUE},
        '{16'h0264, 1'b1, '{1'b1, 1'b1, 16'h0264, 32'h0000_0000}},
        // A sequence seen before whose slot was cleared is taken again.
        '{16'h0163, 1'b1, '{1'b1, 1'b0, 16'h0264, 32'h0000_0000}},
        // Halfway tie, older side, then the longest forward step.
        '{16'h8264, 1'b1, '{1'b1, 1'b0, 16'h0264, 32'h0000_0000}},
        '{16'h8263, 1'b1, '{1'b1, 1'b1, 16'h8263, 32'h0000_0000}},
        // Halfway tie, newer side.
        '{16'h0263, 1'b1, '{1'b1, 1'b1, 16'h0263, 32'h0000_0000}},
        // Top sequence as an old packet, then the ack climbs to the wrap point.
        '{16'hFFFF, 1'b1, '{1'b1, 1'b0, 16'h0263, 32'h0000_0000}},
        '{16'h7FFF, 1'b1, '{1'b1, 1'b1, 16'h7FFF, 32'h0000_0000}},
        '{16'hFFF0, 1'b1, '{1'b1, 1'b1, 16'hFFF0, 32'h0000_0000}},
        // The ack wraps through zero and older packets land on both sides.
        '{16'h0005, 1'b0, NO_VALUE},
        '{16'hFFFF, 1'b0, NO_VALUE},
        '{16'hFFEF, 1'b0, NO_VALUE},
        '{16'h0000, 1'b0, NO_VALUE}
    };

    logic              i_clk;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic              o_in_stall;
    logic [SEQ_W-1:0]  i_seq_number = '0;
    logic              o_out_valid;
    logic              i_out_stall  = 1'b0;
    logic              o_accepted;
    logic              o_is_newer;
    logic [SEQ_W-1:0]  o_ack_seq;
    logic [MASK_W-1:0] o_ack_mask;

    // Tracker state as the testbench sees it.
    logic [SEQ_W-1:0]  trk_ack;
    logic [MASK_W-1:0] trk_mask;
    logic              trk_valid [TABLE_DEPTH];
    logic [SEQ_W-1:0]  trk_tag   [TABLE_DEPTH];

    t_ack_result pending_acks [$];
    int unsigned error_count = 0;

    packet_ack_window_tracker #(
        .SEQ_TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_seq_number (i_seq_number),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_accepted   (o_accepted),
        .o_is_newer   (o_is_newer),
        .o_ack_seq    (o_ack_seq),
        .o_ack_mask   (o_ack_mask)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Applies one received sequence to the tracker state and returns its result.
    function automatic t_ack_result track_packet(input logic [SEQ_W-1:0] seq);
        int unsigned      slot;
        int unsigned      skipped;
        logic [SEQ_W-1:0] delta;
        logic [SEQ_W-1:0] back;
        t_ack_result      res;
        slot         = seq % TABLE_DEPTH;
        delta        = seq - trk_ack;
        res.accepted = 1'b0;
        res.is_newer = 1'b0;
        if (!(trk_valid[slot] && trk_tag[slot] == seq) && delta != '0) begin
            res.accepted = 1'b1;
            res.is_newer = (delta < HALF_RANGE) || (delta == HALF_RANGE && seq < trk_ack);
            if (res.is_newer) begin
                // Skipped sequences lose their slots; a long gap wipes the table.
                skipped = int'(delta) - 1;
                if (skipped >= TABLE_DEPTH) begin
                    for (int i = 0; i < TABLE_DEPTH; i++) trk_valid[i] = 1'b0;
                end else begin
                    for (int i = 1; i <= int'(skipped); i++)
                        trk_valid[(int'(trk_ack) + i) % TABLE_DEPTH] = 1'b0;
                end
                trk_ack  = seq;
                trk_mask = (skipped >= MASK_W) ? '0 :
                           ({trk_mask[MASK_W-2:0], 1'b1} << skipped);
            end else begin
                // An older packet marks its bit only when it falls in the window.
                back = -delta;
                if (back <= MASK_W) trk_mask[back - 1] = 1'b1;
            end
            trk_valid[slot] = 1'b1;
            trk_tag[slot]   = seq;
        end
        res.ack_seq  = trk_ack;
        res.ack_mask = trk_mask;
        return res;
    endfunction

    // Offers one packet after an idle gap and returns once the transfer has happened.
    task automatic send_packet(input logic [SEQ_W-1:0] seq, input int unsigned gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_seq_number <= seq;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Stimulus: directed packets, then random traffic around the moving ack.
    initial begin : packet_source
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] recent_seq [HISTORY_N];
        int unsigned      recent_wr;
        int unsigned      gap;
        int unsigned      pick;
        t_ack_result      predicted;

        trk_ack   = ACK_RESET;
        trk_mask  = '0;
        recent_wr = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            trk_valid[i] = 1'b0;
            trk_tag[i]   = '0;
        end
        for (int i = 0; i < HISTORY_N; i++) recent_seq[i] = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIRECTED_N; k++) begin
            gap = (k < 8) ? 0 : $urandom_range(0, 15);
            send_packet(DIRECTED_ROWS[k].seq, gap);
            predicted = track_packet(DIRECTED_ROWS[k].seq);
            if (DIRECTED_ROWS[k].has_value) pending_acks.push_back(DIRECTED_ROWS[k].value);
            else pending_acks.push_back(predicted);
        end

        for (int k = 0; k < RANDOM_N; k++) begin
            // Mostly a plausible stream near the ack, with some noise mixed in.
            pick = $urandom_range(0, 99);
            if (pick < 50)      seq = trk_ack + $urandom_range(1, 40);
            else if (pick < 65) seq = trk_ack - $urandom_range(1, 34);
            else if (pick < 75) seq = recent_seq[$urandom_range(0, HISTORY_N - 1)];
            else if (pick < 79) seq = trk_ack;
            else if (pick < 82) seq = trk_ack + $urandom_range(41, 300);
            else if (pick < 84) seq = trk_ack + $urandom_range(301, 16'h7FFF);
            else if (pick < 86) seq = trk_ack + HALF_RANGE;
            else                seq = $urandom_range(0, SEQ_MAX);

            // Runs of back-to-back packets between stretches of random gaps.
            gap = ((k % 100) < 30) ? 0 : $urandom_range(0, 15);
            send_packet(seq, gap);
            predicted = track_packet(seq);
            pending_acks.push_back(predicted);
            if (predicted.accepted) begin
                recent_seq[recent_wr] = seq;
                recent_wr = (recent_wr + 1) % HISTORY_N;
            end
        end
        i_in_valid <= 1'b0;

        while (pending_acks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0 && pending_acks.size() == 0) begin
            $display("packet_ack_window_tracker_tb passed");
        end else begin
            $display("packet_ack_window_tracker_tb failed");
        end
        $finish;
    end

    // Result side: random stall per transfer, and one long hold-off to back the block up.
    initial begin : result_sink
        int unsigned n_results;
        int unsigned hold;
        n_results = 0;
        wait (i_rst_n);
        forever begin
            if (n_results == HOLD_OFF_AT)      hold = HOLD_OFF_LEN;
            else if ((n_results % 90) < 25)    hold = 0;
            else                               hold = $urandom_range(0, 15);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            n_results++;
        end
    end

    // Each result transfer is checked against the oldest outstanding expectation.
    always @(posedge i_clk) begin
        t_ack_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_acks.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("Unexpected result at %0t: accepted=%0b newer=%0b ack=%h mask=%h",
                             $realtime, o_accepted, o_is_newer, o_ack_seq, o_ack_mask);
            end else begin
                want = pending_acks.pop_front();
                if (o_accepted !== want.accepted || o_is_newer !== want.is_newer ||
                    o_ack_seq !== want.ack_seq || o_ack_mask !== want.ack_mask) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display({"Mismatch at %0t: accepted %0b/%0b newer %0b/%0b ",
                                  "ack %h/%h mask %h/%h (expected/actual)"},
                                 $realtime, want.accepted, o_accepted, want.is_newer,
                                 o_is_newer, want.ack_seq, o_ack_seq, want.ack_mask,
                                 o_ack_mask);
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    initial begin
        #20_000_000;
        $display("packet_ack_window_tracker_tb failed");
        $finish;
    end

endmodule

FILE: sim.f
sv/pawt_pkg.sv
sv/pawt_ram.sv
sv/packet_ack_window_tracker.sv
sv/pawt_checker.sv
tb/sv/packet_ack_window_tracker_tb.sv
